// ----- rtl/ncap_pkg.sv -----
// Shared types and constants for the nibble capture block.
`default_nettype none

package ncap_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_REARM  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_POST_LIMIT = 1'b1;

  localparam int CFG_W       = 9;
  localparam int IDX_W       = 5;
  localparam int WORD_W      = 64;
  localparam int POS_W       = 9;
  localparam int MID_DEPTH   = 2;
  localparam int OUT_DEPTH   = 4;

  localparam logic [7:0] THRESHOLD_RESET  = 8'd16;
  localparam logic [8:0] POST_LIMIT_RESET = 9'd256;

  // Nibbles that never count toward the trigger.
  localparam logic [3:0] NIB_ZERO = 4'h0;
  localparam logic [3:0] NIB_ONES = 4'hF;

  typedef enum logic [1:0] {
    PH_ARMED = 2'd0,
    PH_ACQ   = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,
    OP_NIBBLE = 2'd1,
    OP_READ   = 2'd2,
    OP_REARM  = 2'd3
  } op_kind_t;

  // Classified work handed from the front end to the back end.
  typedef struct packed {
    op_kind_t         kind;
    logic [3:0]       nib;
    logic [IDX_W-1:0] idx;
  } op_t;

  // One finished result.
  typedef struct packed {
    phase_t            phase;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  pos;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/ncap_fifo.sv -----
// Small register queue used between pipeline parts.
`default_nettype none

module ncap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ncap_front.sv -----
// Front end: gathers sample bits into nibbles and classifies each transaction.
`default_nettype none

module ncap_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [1:0]               cmd,
  input  wire logic                     sample_bit,
  input  wire logic [ncap_pkg::IDX_W-1:0] word_index,
  output ncap_pkg::op_t                 op
);

  logic [1:0] bit_count;
  logic [2:0] bit_gather;
  logic [1:0] bit_count_next;
  logic [2:0] bit_gather_next;

  always_comb begin
    op.kind         = ncap_pkg::OP_IDLE;
    op.nib          = {sample_bit, bit_gather};
    op.idx          = word_index;
    bit_count_next  = bit_count;
    bit_gather_next = bit_gather;
    unique case (cmd)
      ncap_pkg::CMD_SAMPLE: begin
        if (bit_count == 2'd3) begin
          op.kind         = ncap_pkg::OP_NIBBLE;
          bit_count_next  = '0;
          bit_gather_next = '0;
        end else begin
          bit_count_next  = bit_count + 1'b1;
          bit_gather_next = bit_gather | (3'(sample_bit) << bit_count);
        end
      end
      ncap_pkg::CMD_READ:  op.kind = ncap_pkg::OP_READ;
      ncap_pkg::CMD_REARM: op.kind = ncap_pkg::OP_REARM;
      default:             op.kind = ncap_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count  <= '0;
      bit_gather <= '0;
    end else if (accept) begin
      bit_count  <= bit_count_next;
      bit_gather <= bit_gather_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ncap_back.sv -----
// Back end: trigger, capture store, reads and the result queue.
`default_nettype none

module ncap_back #(
  parameter int BUFFER_WORDS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          op_valid,
  input  ncap_pkg::op_t                      op,
  output logic                               op_take,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [ncap_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [1:0]                         capture_phase,
  output logic [ncap_pkg::WORD_W-1:0]        read_word,
  output logic [ncap_pkg::POS_W-1:0]         write_position
);

  localparam int AW    = $clog2(BUFFER_WORDS);
  localparam int PW    = AW + 4;
  localparam int SLOTS = BUFFER_WORDS * 16;
  localparam int OCW   = $clog2(ncap_pkg::OUT_DEPTH + 1);

  ncap_pkg::phase_t phase;
  ncap_pkg::phase_t phase_next;
  logic [7:0]       threshold;
  logic [8:0]       post_limit;
  logic [7:0]       qualify_count;
  logic [7:0]       qualify_count_next;
  logic [8:0]       post_count;
  logic [8:0]       post_count_next;
  logic [PW-1:0]    ptr;
  logic [PW-1:0]    ptr_next;
  logic             wrapped;
  logic [63:0]      cur_word;
  logic [63:0]      word_new;
  logic [63:0]      mem [BUFFER_WORDS];
  logic [63:0]      rd_data;
  logic [OCW-1:0]   outstanding;

  logic             fire;
  logic             store_en;
  logic             qualifies;
  logic [AW-1:0]    ptr_word;
  logic [3:0]       ptr_slot;
  logic [AW+ncap_pkg::IDX_W-1:0] idx_wide;
  logic [AW-1:0]    rd_addr;
  logic             in_range;
  logic             stored;
  logic [PW+8:0]    pos_wide;

  logic             r_valid;
  ncap_pkg::phase_t r_phase;
  logic [8:0]       r_pos;
  logic             r_use;

  ncap_pkg::result_t res_in;
  ncap_pkg::result_t res_out;
  logic              out_full;
  logic              out_deq;

  assign fire      = op_valid && (outstanding < OCW'(ncap_pkg::OUT_DEPTH));
  assign op_take   = fire;
  assign store_en  = fire && (op.kind == ncap_pkg::OP_NIBBLE) && (phase != ncap_pkg::PH_STOP);
  assign qualifies = (op.nib != ncap_pkg::NIB_ZERO) && (op.nib != ncap_pkg::NIB_ONES);
  assign ptr_word  = ptr[PW-1:4];
  assign ptr_slot  = ptr[3:0];
  assign idx_wide  = (AW + ncap_pkg::IDX_W)'(op.idx);
  assign rd_addr   = idx_wide[AW-1:0];
  assign in_range  = (32'(op.idx) < BUFFER_WORDS);
  // The ring fills in order from word zero, so a word holds data once the
  // pointer has passed its first nibble or the ring has wrapped.
  assign stored    = wrapped || (rd_addr < ptr_word) ||
                     ((rd_addr == ptr_word) && (ptr_slot != 4'd0));
  assign word_new  = (ptr_slot == 4'd0) ? 64'(op.nib)
                                        : (cur_word | (64'(op.nib) << {ptr_slot, 2'b00}));
  assign ptr_next  = store_en ? ((ptr == PW'(SLOTS - 1)) ? '0 : ptr + 1'b1) : ptr;
  assign pos_wide  = (PW + 9)'(ptr_next);

  // Trigger next state.
  always_comb begin
    phase_next = phase;
    if (fire) begin
      unique case (op.kind)
        ncap_pkg::OP_NIBBLE: begin
          if (phase == ncap_pkg::PH_ARMED && qualifies && qualify_count >= threshold) begin
            phase_next = ncap_pkg::PH_ACQ;
          end else if (phase == ncap_pkg::PH_ACQ && post_count >= post_limit) begin
            phase_next = ncap_pkg::PH_STOP;
          end
        end
        ncap_pkg::OP_REARM: phase_next = ncap_pkg::PH_ARMED;
        default:            phase_next = phase;
      endcase
    end
  end

  // Trigger counters.
  always_comb begin
    qualify_count_next = qualify_count;
    post_count_next    = post_count;
    if (store_en) begin
      unique case (phase)
        ncap_pkg::PH_ARMED: begin
          post_count_next = '0;
          if (qualifies && qualify_count < threshold) begin
            qualify_count_next = qualify_count + 1'b1;
          end
        end
        ncap_pkg::PH_ACQ: begin
          qualify_count_next = '0;
          if (post_count < post_limit) begin
            post_count_next = post_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ncap_pkg::PH_ARMED;
      qualify_count <= '0;
      post_count    <= '0;
      ptr           <= '0;
      wrapped       <= 1'b0;
      threshold     <= ncap_pkg::THRESHOLD_RESET;
      post_limit    <= ncap_pkg::POST_LIMIT_RESET;
      r_valid       <= 1'b0;
      outstanding   <= '0;
    end else begin
      phase         <= phase_next;
      qualify_count <= qualify_count_next;
      post_count    <= post_count_next;
      ptr           <= ptr_next;
      if (store_en && ptr == PW'(SLOTS - 1)) begin
        wrapped <= 1'b1;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          ncap_pkg::REG_THRESHOLD:  threshold  <= cfg_data[7:0];
          ncap_pkg::REG_POST_LIMIT: post_limit <= cfg_data;
        endcase
      end
      r_valid <= fire;
      case ({fire, out_deq})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[ptr_word] <= word_new;
      cur_word      <= word_new;
    end
    if (fire && op.kind == ncap_pkg::OP_READ) begin
      rd_data <= mem[rd_addr];
    end
    if (fire) begin
      r_phase <= phase_next;
      r_pos   <= pos_wide[8:0];
      r_use   <= (op.kind == ncap_pkg::OP_READ) && in_range && stored;
    end
  end

  assign res_in.phase = r_phase;
  assign res_in.word  = r_use ? rd_data : '0;
  assign res_in.pos   = r_pos;
  assign out_deq      = pop && !empty;

  ncap_fifo #(
    .WIDTH ($bits(ncap_pkg::result_t)),
    .DEPTH (ncap_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_valid),
    .din   (res_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign capture_phase  = res_out.phase;
  assign read_word      = res_out.word;
  assign write_position = res_out.pos;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(r_valid && out_full))
    else $error("result queue overflow");

  a_stop_holds_ptr: assert property (@(posedge clk) disable iff (rst)
    (fire && op.kind == ncap_pkg::OP_NIBBLE && phase == ncap_pkg::PH_STOP) |=> $stable(ptr))
    else $error("nibble stored while stopped");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (fire && op.kind == ncap_pkg::OP_REARM) |=> (phase == ncap_pkg::PH_ARMED))
    else $error("rearm did not arm the trigger");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && op.kind == ncap_pkg::OP_READ && !in_range) |=> !r_use)
    else $error("out of range read used store data");

endmodule

`default_nettype wire

// ----- rtl/nibble_capture_with_trigger.sv -----
// Top level of the nibble capture block with three-phase trigger.
//
//   Channel   Handshake            Payload
//   -------   ------------------   -------------------------------------------
//   input     push / full          cmd, sample_bit, word_index
//   result    empty / pop          capture_phase, read_word, write_position
//   config    cfg_write            cfg_index, cfg_data (no stall)
//
// The back end handles each transaction once, so one input transaction can be
// accepted per clock while full is low. A result passes through the front
// queue and the trigger/store stage, whose registers also capture the store
// read data, into the result queue, where it can be popped. Reset is
// synchronous and clears the trigger, the pointers and both queues; the store
// reads as zero until each word is written.
// A stalled result side fills the four-entry result queue and then the
// two-entry front queue, after which full rises.
`default_nettype none

module nibble_capture_with_trigger #(
  parameter int BUFFER_WORDS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    cmd,
  input  wire logic                          sample_bit,
  input  wire logic [ncap_pkg::IDX_W-1:0]    word_index,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [1:0]                         capture_phase,
  output logic [ncap_pkg::WORD_W-1:0]        read_word,
  output logic [ncap_pkg::POS_W-1:0]         write_position,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [ncap_pkg::CFG_W-1:0]    cfg_data
);

  ncap_pkg::op_t front_op;
  ncap_pkg::op_t back_op;
  logic          accept;
  logic          mid_empty;
  logic          op_take;

  // An input transaction is taken whenever the front queue has room.
  assign accept = push && !full;

  // The front end sorts each transaction into a nibble, read, rearm or no-op,
  // and keeps the bit gatherer so the back end never sees single bits.
  ncap_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .sample_bit (sample_bit),
    .word_index (word_index),
    .op         (front_op)
  );

  // The short queue lets the front keep accepting while the back end waits
  // for room in the result queue.
  ncap_fifo #(
    .WIDTH ($bits(ncap_pkg::op_t)),
    .DEPTH (ncap_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_op),
    .full  (full),
    .pop   (op_take),
    .dout  (back_op),
    .empty (mid_empty)
  );

  // The back end runs the trigger, writes nibbles into the ring and serves
  // reads; each operation produces exactly one result.
  ncap_back #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (!mid_empty),
    .op             (back_op),
    .op_take        (op_take),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pop            (pop),
    .empty          (empty),
    .capture_phase  (capture_phase),
    .read_word      (read_word),
    .write_position (write_position)
  );

endmodule

`default_nettype wire
